[rtl/hpt_pkg.sv]
// Package for humidity_pressure_temp_compensation: register indexes, constants,
// pipeline payload types and the shared 64-bit multiply and divide step functions.
// No dependencies.
`timescale 1ns / 1ps

package hpt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIXED_TRIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_TRIM   = 3'd4;

	// divider geometry
	localparam int QUOT_W              = 64;
	localparam int DSR_W               = 32;
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;

	// temperature
	localparam logic signed [25:0] TF_MIN   = -26'sd524288;
	localparam logic signed [25:0] TF_MAX   = 26'sd524287;
	localparam logic signed [23:0] TC_MUL   = 24'sd5;
	localparam logic signed [23:0] TC_RND   = 24'sd128;
	localparam logic signed [15:0] TC_MIN   = -16'sd4000;
	localparam logic signed [15:0] TC_MAX   = 16'sd8500;

	// pressure
	localparam logic signed [20:0] P_T_OFS  = 21'sd128000;
	localparam logic [20:0]        P_BASE   = 21'd1048576;
	localparam logic signed [50:0] P_BIAS   = 51'sd140737488355328;
	localparam logic [11:0]        P_SCALE  = 12'd3125;
	localparam logic signed [63:0] P_MAX    = 64'sd33554431;

	// humidity
	localparam logic signed [20:0] H_T_OFS  = 21'sd76800;
	localparam logic signed [35:0] H_RND_A  = 36'sd16384;
	localparam logic signed [19:0] H_OFS_C  = 20'sd32768;
	localparam logic signed [28:0] H_BASE   = 29'sd2097152;
	localparam logic signed [44:0] H_RND_B  = 45'sd8192;
	localparam logic signed [63:0] H_MAX    = 64'sd419430400;

	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] cr;
	} mulp_t;

	typedef struct packed {
		logic [DSR_W-1:0]  rem;
		logic [QUOT_W-1:0] nq;
	} div_t;

	typedef struct packed {
		logic signed [19:0] tf;
		logic signed [14:0] tc;
		logic [16:0]        hum;
		logic               qneg;
		logic               pvld;
	} side_t;

	// 64x64 product modulo 2^64, first half: low product and cross terms
	function automatic mulp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
		mulp_t r;
		r.ll = 64'(a[31:0]) * 64'(b[31:0]);
		r.cr = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
		return r;
	endfunction

	function automatic logic [63:0] mul_join(input mulp_t p);
		return p.ll + {p.cr, 32'h0};
	endfunction

	// one restoring division step; remainder stays below the divisor
	function automatic div_t div_step(input div_t cur, input logic [DSR_W-1:0] d);
		div_t r;
		logic [DSR_W:0] trial;
		logic           qb;
		trial = {cur.rem, cur.nq[QUOT_W-1]};
		qb    = trial >= {1'b0, d};
		r.rem = qb ? DSR_W'(trial - {1'b0, d}) : trial[DSR_W-1:0];
		r.nq  = {cur.nq[QUOT_W-2:0], qb};
		return r;
	endfunction

	function automatic div_t div_stage(input div_t cur, input logic [DSR_W-1:0] d);
		div_t r;
		r = cur;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			r = div_step(r, d);
		end
		return r;
	endfunction

endpackage

[rtl/hpt_div.sv]
// Pipelined unsigned divider, 64-bit dividend by 32-bit divisor, a fixed number
// of restoring steps per stage; carries a side payload. Uses hpt_pkg.
`timescale 1ns / 1ps

module hpt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [hpt_pkg::QUOT_W-1:0]    dividend,
	input  logic [hpt_pkg::DSR_W-1:0]     divisor,
	input  hpt_pkg::side_t                side_in,
	output logic                          out_vld,
	output logic [hpt_pkg::QUOT_W-1:0]    quotient,
	output hpt_pkg::side_t                side_out
);

	logic                        vld_s  [hpt_pkg::DIV_STAGES];
	hpt_pkg::div_t               st_s   [hpt_pkg::DIV_STAGES];
	logic [hpt_pkg::DSR_W-1:0]   dsr_s  [hpt_pkg::DIV_STAGES];
	hpt_pkg::side_t              side_s [hpt_pkg::DIV_STAGES];

	for (genvar g = 0; g < hpt_pkg::DIV_STAGES; g++) begin : g_stage
		hpt_pkg::div_t             cur;
		logic [hpt_pkg::DSR_W-1:0] dsr;
		hpt_pkg::side_t            sd;
		logic                      vin;

		if (g == 0) begin : g_head
			assign cur = '{rem: '0, nq: dividend};
			assign dsr = divisor;
			assign sd  = side_in;
			assign vin = in_vld;
		end else begin : g_body
			assign cur = st_s[g-1];
			assign dsr = dsr_s[g-1];
			assign sd  = side_s[g-1];
			assign vin = vld_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[g]   <= hpt_pkg::div_stage(cur, dsr);
				dsr_s[g]  <= dsr;
				side_s[g] <= sd;
			end
		end
	end

	assign out_vld  = vld_s[hpt_pkg::DIV_STAGES-1];
	assign quotient = st_s[hpt_pkg::DIV_STAGES-1].nq;
	assign side_out = side_s[hpt_pkg::DIV_STAGES-1];

endmodule

[rtl/humidity_pressure_temp_compensation.sv]
// Top level of the integer temperature / pressure / humidity compensation pipeline.
// Uses hpt_pkg and hpt_div.
//
// One raw sample triple enters per cycle and one compensated result leaves per
// cycle unless the output stalls. The pipe holds 13 stages for the temperature,
// pressure prelude and the complete humidity path, 32 stages of the pressure
// divider at two quotient bits per stage, and 6 stages of pressure post-processing
// ending in the output register. The whole pipe advances when the output register
// is empty or its item is taken, so a stalled output holds every stage in place.
// Trim registers are written through wr_en/wr_index/wr_data and must only change
// while no item is in flight; indexes above 4 are ignored.
`timescale 1ns / 1ps

module humidity_pressure_temp_compensation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [hpt_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [hpt_pkg::CFG_DATA_W-1:0]    wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [19:0]                       raw_temperature,
	input  logic [19:0]                       raw_pressure,
	input  logic [15:0]                       raw_humidity,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [19:0]                fine_temperature,
	output logic signed [14:0]                temperature_centi,
	output logic [24:0]                       pressure_q24_8,
	output logic                              pressure_valid,
	output logic [16:0]                       humidity_q22_10
);

	// trim registers
	logic [47:0] temp_trim_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [47:0] mixed_trim_q;
	logic [31:0] hum_trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q  <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			mixed_trim_q <= '0;
			hum_trim_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				hpt_pkg::REG_TEMP_TRIM:  temp_trim_q  <= wr_data[47:0];
				hpt_pkg::REG_PRESS_LO:   press_lo_q   <= wr_data;
				hpt_pkg::REG_PRESS_HI:   press_hi_q   <= wr_data;
				hpt_pkg::REG_MIXED_TRIM: mixed_trim_q <= wr_data[47:0];
				hpt_pkg::REG_HUM_TRIM:   hum_trim_q   <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = temp_trim_q[15:0];
	assign t2 = $signed(temp_trim_q[31:16]);
	assign t3 = $signed(temp_trim_q[47:32]);
	assign p1 = press_lo_q[15:0];
	assign p2 = $signed(press_lo_q[31:16]);
	assign p3 = $signed(press_lo_q[47:32]);
	assign p4 = $signed(press_lo_q[63:48]);
	assign p5 = $signed(press_hi_q[15:0]);
	assign p6 = $signed(press_hi_q[31:16]);
	assign p7 = $signed(press_hi_q[47:32]);
	assign p8 = $signed(press_hi_q[63:48]);
	assign p9 = $signed(mixed_trim_q[15:0]);
	assign h1 = mixed_trim_q[23:16];
	assign h2 = $signed(mixed_trim_q[39:24]);
	assign h3 = mixed_trim_q[47:40];
	assign h4 = $signed(hum_trim_q[11:0]);
	assign h5 = $signed(hum_trim_q[23:12]);
	assign h6 = $signed(hum_trim_q[31:24]);

	// flow control
	logic adv;
	logic vld_p6;
	assign adv      = !vld_p6 | out_ready;
	assign in_ready = adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic vld_dv, vld_p1, vld_p2, vld_p3, vld_p4, vld_p5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_p1  <= 1'b0;
			vld_p2  <= 1'b0;
			vld_p3  <= 1'b0;
			vld_p4  <= 1'b0;
			vld_p5  <= 1'b0;
			vld_p6  <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_p1  <= vld_dv;
			vld_p2  <= vld_p1;
			vld_p3  <= vld_p2;
			vld_p4  <= vld_p3;
			vld_p5  <= vld_p4;
			vld_p6  <= vld_p5;
		end
	end

	// ---------------- front pipeline ----------------
	logic signed [34:0] ta_s1, dd_s1;
	logic [19:0]        raw_p_s1, raw_p_s2, raw_p_s3;
	logic [15:0]        raw_h_s1, raw_h_s2, raw_h_s3, raw_h_s4;
	logic signed [23:0] ta_s2;
	logic signed [38:0] tb_s2;
	logic signed [19:0] tf_s3, tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9;
	logic signed [19:0] tf_s10, tf_s11, tf_s12, tf_s13;
	logic signed [14:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9;
	logic signed [14:0] tc_s10, tc_s11, tc_s12, tc_s13;
	logic signed [20:0] v1_s4, x_s4;
	logic [20:0]        pn_s4, pn_s5, pn_s6;
	logic signed [41:0] sq_s5;
	logic signed [36:0] v1p5_s5, v1p2_s5;
	logic signed [35:0] ahp_s5;
	logic signed [17:0] hx6_s5;
	logic signed [19:0] hx3_s5;
	logic signed [57:0] v2_s6;
	logic signed [49:0] v1b_s6;
	logic signed [21:0] ah_s6, ah_s7;
	logic signed [28:0] hb1_s6;
	logic [41:0]        ml_s7;
	logic signed [41:0] mh_s7;
	logic [63:0]        num_s7;
	logic signed [30:0] hb_s7;
	logic signed [30:0] v1d_s8, den_s9;
	logic [43:0]        nl_s8;
	logic [31:0]        nh_s8;
	logic signed [52:0] hv_s8, hv_s9, hv_s10, hv_s11;
	logic [63:0]        numer_s9;
	hpt_pkg::mulp_t     hm1_s9, hm2_s11;
	logic [63:0]        mag_n_s10, mag_n_s11, mag_n_s12, mag_n_s13;
	logic [31:0]        mag_d_s10, mag_d_s11, mag_d_s12, mag_d_s13;
	logic               qneg_s10, qneg_s11, qneg_s12, qneg_s13;
	logic               pv_s10, pv_s11, pv_s12, pv_s13;
	logic signed [63:0] hsq7_s10;
	logic signed [63:0] hres_s12;
	logic [16:0]        hum_s13;

	logic signed [18:0] tdiff;
	logic signed [17:0] dt;
	logic signed [25:0] tsum;
	logic signed [19:0] tf_sat;
	logic signed [23:0] t5;
	logic signed [15:0] t8;
	logic signed [14:0] tc_sat;
	logic signed [50:0] m;
	logic signed [63:0] pr;
	logic [30:0]        den_neg;
	logic signed [63:0] hd;
	logic [28:0]        hcl;

	always_comb begin
		tdiff = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
		dt    = $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, t1});

		tsum = 26'(ta_s2) + 26'(tb_s2 >>> 14);
		if (tsum < hpt_pkg::TF_MIN) begin
			tf_sat = 20'(hpt_pkg::TF_MIN);
		end else if (tsum > hpt_pkg::TF_MAX) begin
			tf_sat = 20'(hpt_pkg::TF_MAX);
		end else begin
			tf_sat = 20'(tsum);
		end

		t5 = 24'(tf_s3) * hpt_pkg::TC_MUL + hpt_pkg::TC_RND;
		t8 = 16'(t5 >>> 8);
		if (t8 < hpt_pkg::TC_MIN) begin
			tc_sat = 15'(hpt_pkg::TC_MIN);
		end else if (t8 > hpt_pkg::TC_MAX) begin
			tc_sat = 15'(hpt_pkg::TC_MAX);
		end else begin
			tc_sat = 15'(t8);
		end

		m       = 51'(v1b_s6) + hpt_pkg::P_BIAS;
		pr      = $signed(64'(ml_s7) + (64'(mh_s7) << 26));
		den_neg = 31'(~den_s9) + 31'd1;
		hd      = 64'(hv_s8 >>> 15);

		if (hres_s12 < 64'sd0) begin
			hcl = '0;
		end else if (hres_s12 > hpt_pkg::H_MAX) begin
			hcl = 29'(hpt_pkg::H_MAX);
		end else begin
			hcl = 29'(hres_s12);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: temperature products
			ta_s1    <= 35'(tdiff * t2);
			dd_s1    <= 35'(dt * dt);
			raw_p_s1 <= raw_pressure;
			raw_h_s1 <= raw_humidity;
			// s2
			ta_s2    <= 24'(ta_s1 >>> 11);
			tb_s2    <= 39'(24'(dd_s1 >>> 12) * t3);
			raw_p_s2 <= raw_p_s1;
			raw_h_s2 <= raw_h_s1;
			// s3: fine temperature
			tf_s3    <= tf_sat;
			raw_p_s3 <= raw_p_s2;
			raw_h_s3 <= raw_h_s2;
			// s4
			tf_s4    <= tf_s3;
			tc_s4    <= tc_sat;
			v1_s4    <= 21'(tf_s3) - hpt_pkg::P_T_OFS;
			x_s4     <= 21'(tf_s3) - hpt_pkg::H_T_OFS;
			pn_s4    <= hpt_pkg::P_BASE - {1'b0, raw_p_s3};
			raw_h_s4 <= raw_h_s3;
			// s5
			tf_s5    <= tf_s4;
			tc_s5    <= tc_s4;
			pn_s5    <= pn_s4;
			sq_s5    <= 42'(v1_s4 * v1_s4);
			v1p5_s5  <= 37'(v1_s4 * p5);
			v1p2_s5  <= 37'(v1_s4 * p2);
			ahp_s5   <= $signed({6'b0, raw_h_s4, 14'b0}) - (36'(h4) <<< 20)
				- 36'(h5 * x_s4) + hpt_pkg::H_RND_A;
			hx6_s5   <= 18'((29'(x_s4) * 29'(h6)) >>> 10);
			hx3_s5   <= 20'((30'(x_s4) * 30'($signed({1'b0, h3}))) >>> 11) + hpt_pkg::H_OFS_C;
			// s6
			tf_s6    <= tf_s5;
			tc_s6    <= tc_s5;
			pn_s6    <= pn_s5;
			v2_s6    <= 58'(sq_s5 * p6) + (58'(v1p5_s5) <<< 17) + (58'(p4) <<< 35);
			v1b_s6   <= 50'((58'(sq_s5) * 58'(p3)) >>> 8) + (50'(v1p2_s5) <<< 12);
			ah_s6    <= 22'(ahp_s5 >>> 15);
			hb1_s6   <= 29'((38'(hx6_s5) * 38'(hx3_s5)) >>> 10) + hpt_pkg::H_BASE;
			// s7
			tf_s7    <= tf_s6;
			tc_s7    <= tc_s6;
			ml_s7    <= 42'(m[25:0]) * 42'(p1);
			mh_s7    <= 42'($signed(m[50:26]) * $signed({1'b0, p1}));
			num_s7   <= {12'b0, pn_s6, 31'b0} - 64'(v2_s6);
			ah_s7    <= ah_s6;
			hb_s7    <= 31'((45'(hb1_s6) * 45'(h2) + hpt_pkg::H_RND_B) >>> 14);
			// s8
			tf_s8    <= tf_s7;
			tc_s8    <= tc_s7;
			v1d_s8   <= 31'(pr >>> 33);
			nl_s8    <= 44'(num_s7[31:0]) * 44'(hpt_pkg::P_SCALE);
			nh_s8    <= 32'(num_s7[63:32] * 32'(hpt_pkg::P_SCALE));
			hv_s8    <= 53'(ah_s7 * hb_s7);
			// s9
			tf_s9    <= tf_s8;
			tc_s9    <= tc_s8;
			numer_s9 <= 64'(nl_s8) + {nh_s8, 32'h0};
			den_s9   <= v1d_s8;
			hv_s9    <= hv_s8;
			hm1_s9   <= hpt_pkg::mul_parts(hd, hd);
			// s10: sign and magnitude for the divider
			tf_s10    <= tf_s9;
			tc_s10    <= tc_s9;
			mag_n_s10 <= numer_s9[63] ? (~numer_s9 + 64'd1) : numer_s9;
			mag_d_s10 <= {1'b0, den_s9[30] ? den_neg : den_s9};
			qneg_s10  <= numer_s9[63] ^ den_s9[30];
			pv_s10    <= den_s9 != '0;
			hv_s10    <= hv_s9;
			hsq7_s10  <= $signed(hpt_pkg::mul_join(hm1_s9)) >>> 7;
			// s11
			tf_s11    <= tf_s10;
			tc_s11    <= tc_s10;
			mag_n_s11 <= mag_n_s10;
			mag_d_s11 <= mag_d_s10;
			qneg_s11  <= qneg_s10;
			pv_s11    <= pv_s10;
			hv_s11    <= hv_s10;
			hm2_s11   <= hpt_pkg::mul_parts(hsq7_s10, {56'b0, h1});
			// s12
			tf_s12    <= tf_s11;
			tc_s12    <= tc_s11;
			mag_n_s12 <= mag_n_s11;
			mag_d_s12 <= mag_d_s11;
			qneg_s12  <= qneg_s11;
			pv_s12    <= pv_s11;
			hres_s12  <= 64'(hv_s11) - ($signed(hpt_pkg::mul_join(hm2_s11)) >>> 4);
			// s13
			tf_s13    <= tf_s12;
			tc_s13    <= tc_s12;
			mag_n_s13 <= mag_n_s12;
			mag_d_s13 <= mag_d_s12;
			qneg_s13  <= qneg_s12;
			pv_s13    <= pv_s12;
			hum_s13   <= hcl[28:12];
		end
	end

	// ---------------- divider ----------------
	hpt_pkg::side_t      side_in, side_dv;
	logic [63:0]         quot_dv;

	assign side_in = '{tf: tf_s13, tc: tc_s13, hum: hum_s13, qneg: qneg_s13, pvld: pv_s13};

	hpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s13),
		.dividend (mag_n_s13),
		.divisor  (mag_d_s13),
		.side_in  (side_in),
		.out_vld  (vld_dv),
		.quotient (quot_dv),
		.side_out (side_dv)
	);

	// ---------------- pressure post-processing ----------------
	hpt_pkg::side_t     side_p1, side_p2, side_p3, side_p4, side_p5;
	logic signed [63:0] p_p1, p_p2, p_p3, p_p4;
	logic signed [63:0] s_p2, s_p3;
	hpt_pkg::mulp_t     pm9_p2, pm8_p2, pm3_p4;
	logic [63:0]        m1_p3, bprod_p3;
	logic signed [63:0] bq_p4, sum1_p5;

	logic signed [63:0] ps;
	logic signed [63:0] pp;
	logic [24:0]        press_sat;

	logic signed [19:0] tf_p6;
	logic signed [14:0] tc_p6;
	logic [24:0]        press_p6;
	logic               pv_p6;
	logic [16:0]        hum_p6;

	always_comb begin
		ps = p_p1 >>> 13;
		pp = (sum1_p5 >>> 8) + (64'(p7) <<< 4);
		if (pp < 64'sd0) begin
			press_sat = '0;
		end else if (pp > hpt_pkg::P_MAX) begin
			press_sat = 25'(hpt_pkg::P_MAX);
		end else begin
			press_sat = 25'(pp);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_p1  <= side_dv;
			p_p1     <= side_dv.qneg ? $signed(~quot_dv + 64'd1) : $signed(quot_dv);
			side_p2  <= side_p1;
			p_p2     <= p_p1;
			s_p2     <= ps;
			pm9_p2   <= hpt_pkg::mul_parts(64'(p9), ps);
			pm8_p2   <= hpt_pkg::mul_parts(64'(p8), p_p1);
			side_p3  <= side_p2;
			p_p3     <= p_p2;
			s_p3     <= s_p2;
			m1_p3    <= hpt_pkg::mul_join(pm9_p2);
			bprod_p3 <= hpt_pkg::mul_join(pm8_p2);
			side_p4  <= side_p3;
			p_p4     <= p_p3;
			pm3_p4   <= hpt_pkg::mul_parts(m1_p3, s_p3);
			bq_p4    <= $signed(bprod_p3) >>> 19;
			side_p5  <= side_p4;
			sum1_p5  <= p_p4 + ($signed(hpt_pkg::mul_join(pm3_p4)) >>> 25) + bq_p4;
			tf_p6    <= side_p5.tf;
			tc_p6    <= side_p5.tc;
			hum_p6   <= side_p5.hum;
			pv_p6    <= side_p5.pvld;
			press_p6 <= side_p5.pvld ? press_sat : '0;
		end
	end

	assign out_valid         = vld_p6;
	assign fine_temperature  = tf_p6;
	assign temperature_centi = tc_p6;
	assign pressure_q24_8    = press_p6;
	assign pressure_valid    = pv_p6;
	assign humidity_q22_10   = hum_p6;

endmodule

[tb/tb_top.sv]
// Testbench for humidity_pressure_temp_compensation: a queue-fed driver and a monitor
// check every result against an in-bench integer compensation predictor.
// Depends on hpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int LATENCY = 51;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [19:0] rt;
		logic [19:0] rp;
		logic [15:0] rh;
	} sample_t;

	typedef struct {
		logic signed [19:0] tf;
		logic signed [14:0] tc;
		logic [24:0]        press;
		logic               pvld;
		logic [16:0]        hum;
	} comp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [hpt_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [hpt_pkg::CFG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic [15:0] raw_humidity = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [19:0] fine_temperature;
	logic signed [14:0] temperature_centi;
	logic [24:0] pressure_q24_8;
	logic pressure_valid;
	logic [16:0] humidity_q22_10;

	humidity_pressure_temp_compensation uut (.*);

	always #5 clk = ~clk;

	logic [63:0] trim [0:4] = '{default: 64'd0};
	sample_t pending_samples [$];
	comp_t   expected_comp [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	longint cycles = 0;

	function automatic longint sx(input logic [63:0] v, input int pos, input int w);
		logic [63:0] x;
		x = (v >> pos) & ((64'd1 << w) - 1);
		if (x[w-1])
			x = x | ~((64'd1 << w) - 1);
		return longint'(x);
	endfunction

	function automatic longint ux(input logic [63:0] v, input int pos, input int w);
		return longint'((v >> pos) & ((64'd1 << w) - 1));
	endfunction

	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic comp_t compensate(input sample_t s);
		comp_t r;
		longint adt, adp, adh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint h1, h2, h3, h4, h5, h6, a, b, d, t, tc, v1, v2, p, x, v;
		adt = longint'(s.rt); adp = longint'(s.rp); adh = longint'(s.rh);
		t1 = ux(trim[0], 0, 16); t2 = sx(trim[0], 16, 16); t3 = sx(trim[0], 32, 16);
		p1 = ux(trim[1], 0, 16); p2 = sx(trim[1], 16, 16);
		p3 = sx(trim[1], 32, 16); p4 = sx(trim[1], 48, 16);
		p5 = sx(trim[2], 0, 16); p6 = sx(trim[2], 16, 16);
		p7 = sx(trim[2], 32, 16); p8 = sx(trim[2], 48, 16);
		p9 = sx(trim[3], 0, 16); h1 = ux(trim[3], 16, 8);
		h2 = sx(trim[3], 24, 16); h3 = ux(trim[3], 40, 8);
		h4 = sx(trim[4], 0, 12); h5 = sx(trim[4], 12, 12); h6 = sx(trim[4], 24, 8);

		a = (((adt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (adt >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		t = clampl(a + b, -64'sd524288, 64'sd524287);
		tc = clampl((t * 64'sd5 + 64'sd128) >>> 8, -64'sd4000, 64'sd8500);
		r.tf = t[19:0];
		r.tc = tc[14:0];

		v1 = t - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press = '0;
		r.pvld = 1'b0;
		if (v1 != 0) begin
			p = 64'sd1048576 - adp;
			p = ((p <<< 31) - v2) * 64'sd3125;
			p = (v1 == -64'sd1) ? (64'sd0 - p) : (p / v1);
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			p = clampl(p, 64'sd0, 64'sd33554431);
			r.press = p[24:0];
			r.pvld = 1'b1;
		end

		x = t - 64'sd76800;
		a = ((adh <<< 14) - (h4 <<< 20) - h5 * x + 64'sd16384) >>> 15;
		b = (((((((x * h6) >>> 10) * (((x * h3) >>> 11) + 64'sd32768)) >>> 10)
			+ 64'sd2097152) * h2) + 64'sd8192) >>> 14;
		v = a * b;
		d = v >>> 15;
		v = v - ((((d * d) >>> 7) * h1) >>> 4);
		v = clampl(v, 64'sd0, 64'sd419430400) >>> 12;
		r.hum = v[16:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s.rt = raw_temperature; s.rp = raw_pressure; s.rh = raw_humidity;
				expected_comp.push_back(compensate(s));
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					raw_temperature <= s.rt;
					raw_pressure <= s.rp;
					raw_humidity <= s.rh;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		comp_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_comp.size() == 0) begin
					$error("unexpected result item");
					errors = errors + 1;
				end else begin
					e = expected_comp.pop_front();
					if (fine_temperature !== e.tf) begin
						$error("fine_temperature exp %0d got %0d", e.tf, fine_temperature);
						errors = errors + 1;
					end
					if (temperature_centi !== e.tc) begin
						$error("temperature_centi exp %0d got %0d", e.tc, temperature_centi);
						errors = errors + 1;
					end
					if (pressure_q24_8 !== e.press) begin
						$error("pressure_q24_8 exp %0d got %0d", e.press, pressure_q24_8);
						errors = errors + 1;
					end
					if (pressure_valid !== e.pvld) begin
						$error("pressure_valid exp %0d got %0d", e.pvld, pressure_valid);
						errors = errors + 1;
					end
					if (humidity_q22_10 !== e.hum) begin
						$error("humidity_q22_10 exp %0d got %0d", e.hum, humidity_q22_10);
						errors = errors + 1;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() > 0 || in_valid || expected_comp.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic load_trims(input logic [63:0] r0, r1, r2, r3, r4);
		logic [63:0] vals [0:4];
		vals = '{r0, r1, r2, r3, r4};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			wr_en <= 1'b1;
			wr_index <= i[hpt_pkg::CFG_IDX_W-1:0];
			wr_data <= vals[i];
			trim[i] = vals[i];
		end
		// out-of-range index must be ignored
		@(posedge clk);
		wr_index <= 3'd7;
		wr_data <= {$urandom, $urandom};
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_sample(input logic [19:0] rt, rp, input logic [15:0] rh);
		sample_t s;
		s.rt = rt; s.rp = rp; s.rh = rh;
		pending_samples.push_back(s);
	endtask

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: add_sample($urandom, $urandom, $urandom);
				1: add_sample($urandom_range(1048575, 1040000), $urandom_range(8000),
					$urandom_range(65535, 60000));
				default: add_sample($urandom_range(560000, 480000),
					$urandom_range(480000, 250000), $urandom_range(40000, 15000));
			endcase
		end
	endtask

	function automatic logic [63:0] pack4(input logic [15:0] a, b, c, d);
		return {d, c, b, a};
	endfunction

	logic [63:0] typ_t, typ_pl, typ_ph, typ_m, typ_h;

	initial begin
		typ_t  = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
		typ_pl = pack4(16'd36477, -16'sd10685, 16'd3024, 16'd2855);
		typ_ph = pack4(16'd140, -16'sd7, 16'd15500, -16'sd14600);
		typ_m  = {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000};
		typ_h  = {8'd30, 12'd50, 12'd313};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nominal trims, directed extremes, no idling
		load_trims(typ_t, typ_pl, typ_ph, typ_m, typ_h);
		add_sample(20'd0, 20'd0, 16'd0);
		add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		add_sample(20'd519888, 20'd415148, 16'd30000);
		add_sample(20'd0, 20'hFFFFF, 16'hFFFF);
		add_sample(20'hFFFFF, 20'd0, 16'd0);
		add_sample(20'd440000, 20'd300000, 16'd20000);
		add_sample(20'd600000, 20'd500000, 16'd40000);
		add_sample(20'h55555, 20'hAAAAA, 16'h5555);
		add_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
		add_random(120);
		wait_drained();

		// zero pressure divisor, sender idle
		send_idle_pct = 76;
		load_trims(typ_t, 64'h0, typ_ph, typ_m, typ_h);
		add_sample(20'd519888, 20'd415148, 16'd30000);
		add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		add_random(100);
		wait_drained();

		// all-ones trims, receiver stalling
		send_idle_pct = 0;
		stall_pct = 76;
		load_trims({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
		add_sample(20'd0, 20'd0, 16'd0);
		add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		add_random(100);
		wait_drained();

		// all-zero trims, both idle
		send_idle_pct = 22;
		stall_pct = 22;
		load_trims(64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
		add_random(60);
		wait_drained();

		// random trims, mixed idling per block
		for (int k = 0; k < 4; k++) begin
			send_idle_pct = (k == 1) ? 76 : (k == 3 ? 22 : 0);
			stall_pct = (k == 2) ? 76 : (k == 3 ? 22 : 0);
			if (k[0])
				load_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			else
				load_trims(typ_t ^ 64'($urandom_range(255)), typ_pl ^ 64'($urandom_range(255)),
					typ_ph ^ 64'($urandom_range(255)), typ_m ^ 64'($urandom_range(255)),
					typ_h ^ 64'($urandom_range(255)));
			add_random(60);
			wait_drained();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
